@@ hdl/gclu_pkg.sv @@
// gclu_pkg: shared types, codes and constants for the GCD/LCM unit.
// Used by gclu_alu, gclu_engine, gcd_lcm_unit_core and gclu_core_checker.
// No dependencies.
package gclu_pkg;

	localparam int DATA_W = 64;
	localparam int RES_W  = DATA_W - 1;
	localparam int CNT_W  = $clog2(DATA_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

	localparam logic CMD_GCD = 1'b0;
	localparam logic CMD_LCM = 1'b1;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_NONINT = 2'd1;
	localparam logic [1:0] STAT_OVF    = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TEST,
		S_DIV,
		S_MUL,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              cmd;
		logic [DATA_W-1:0] lhs_val;
		logic              left_integral;
		logic [DATA_W-1:0] rhs_val;
		logic              right_integral;
	} req_t;

	typedef struct packed {
		logic [RES_W-1:0] result;
		logic [1:0]       status;
	} res_t;

endpackage

@@ hdl/gcd_lcm_unit_core.sv @@
// gcd_lcm_unit_core: top level of the GCD/LCM unit; stream ports and result register.
// Depends on gclu_pkg and gclu_engine.
//
// Input stream (s_axis): one transaction is one request. tdata carries the two
// signed 64-bit operands, tuser the command and the two integer flags.
// Output stream (m_axis): one transaction per request, tdata the 63-bit result,
// tuser the status (0 ok, 1 non-integer operand, 2 overflow; result 0 unless ok).
// A request is registered into the engine; each Euclid remainder step is one
// zero test plus a restoring divide on the shared adder, and one final test
// passes the result on towards the output register. LCM adds a divide by the
// GCD and a shift-add multiply. There are at most 91 remainder steps.
// Non-integer operands and LCM with a zero operand go straight to done.
// s_axis_tready is high only while the engine is idle; the engine frees up as
// soon as its result moves into the output register, so a new request is taken
// while a result still waits on a stalled receiver. A stalled receiver holds the
// output; the engine then holds its finished result until the register frees.
// Reset returns the engine to idle and empties the output register.
module gcd_lcm_unit_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,  // lhs_val[63:0], rhs_val[127:64]
	input  logic [2:0]    s_axis_tuser,  // cmd[0], left_integral[1], right_integral[2]
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [63:0]   m_axis_tdata,  // result[62:0], zero pad[63]
	output logic [1:0]    m_axis_tuser   // status[1:0]
);
	import gclu_pkg::*;

	logic eng_idle, eng_done, eng_ack, start, load;
	req_t req;
	res_t eng_res;
	res_t out_res_q;
	logic out_valid_q;

	assign start = s_axis_tvalid && s_axis_tready;
	assign req   = '{cmd:            s_axis_tuser[0],
	                 lhs_val:        s_axis_tdata[DATA_W-1:0],
	                 left_integral:  s_axis_tuser[1],
	                 rhs_val:        s_axis_tdata[2*DATA_W-1:DATA_W],
	                 right_integral: s_axis_tuser[2]};

	gclu_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.idle   (eng_idle),
		.done   (eng_done),
		.res    (eng_res),
		.ack    (eng_ack)
	);

	assign load    = eng_done && (!out_valid_q || m_axis_tready);
	assign eng_ack = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q <= eng_res;
		end
	end

	assign s_axis_tready = eng_idle;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_res_q.result};
	assign m_axis_tuser  = out_res_q.status;

endmodule

@@ hdl/gclu_alu.sv @@
// gclu_alu: shared 65-bit adder/subtractor used for every divide and multiply step.
// Depends on gclu_pkg.
module gclu_alu (
	input  logic [gclu_pkg::DATA_W:0] opa,
	input  logic [gclu_pkg::DATA_W:0] opb,
	input  logic                      sub,
	output logic [gclu_pkg::DATA_W:0] sum
);
	import gclu_pkg::*;

	logic [DATA_W:0] opb_x;

	assign opb_x = sub ? ~opb : opb;
	assign sum   = opa + opb_x + {{DATA_W{1'b0}}, sub};

endmodule

@@ hdl/gclu_engine.sv @@
// gclu_engine: sequencer and datapath registers; Euclid by restoring division,
// then for LCM a quotient and shift-add multiply with sticky overflow, all on one gclu_alu.
// Depends on gclu_pkg and gclu_alu.
module gclu_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  gclu_pkg::req_t req,
	output logic           idle,
	output logic           done,
	output gclu_pkg::res_t res,
	input  logic           ack
);
	import gclu_pkg::*;

	state_t            state_q, state_d;
	logic              is_lcm_q, is_lcm_d;
	logic              quot_q, quot_d;
	logic              ovf_q, ovf_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [DATA_W-1:0] a_q, a_d;
	logic [DATA_W-1:0] b_q, b_d;
	logic [DATA_W-1:0] amag_q, amag_d;
	logic [DATA_W-1:0] bmag_q, bmag_d;
	logic [DATA_W-1:0] quo_q, quo_d;
	logic [RES_W-1:0]  rem_q, rem_d;
	logic [RES_W-1:0]  acc_q, acc_d;
	res_t              res_q, res_d;

	logic [DATA_W:0]   alu_a, alu_b, alu_sum;
	logic              alu_sub;
	logic [DATA_W-1:0] lmag, rmag;

	gclu_alu u_alu (
		.opa (alu_a),
		.opb (alu_b),
		.sub (alu_sub),
		.sum (alu_sum)
	);

	assign lmag = req.lhs_val[DATA_W-1] ? ({DATA_W{1'b0}} - req.lhs_val) : req.lhs_val;
	assign rmag = req.rhs_val[DATA_W-1] ? ({DATA_W{1'b0}} - req.rhs_val) : req.rhs_val;

	always_comb begin
		logic qbit;
		logic ovf_n;
		state_d  = state_q;
		is_lcm_d = is_lcm_q;
		quot_d   = quot_q;
		ovf_d    = ovf_q;
		cnt_d    = cnt_q;
		a_d      = a_q;
		b_d      = b_q;
		amag_d   = amag_q;
		bmag_d   = bmag_q;
		quo_d    = quo_q;
		rem_d    = rem_q;
		acc_d    = acc_q;
		res_d    = res_q;
		alu_a    = {1'b0, rem_q, quo_q[DATA_W-1]};
		alu_b    = {1'b0, b_q};
		alu_sub  = 1'b1;
		qbit     = 1'b0;
		ovf_n    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					a_d      = lmag;
					b_d      = rmag;
					amag_d   = lmag;
					bmag_d   = rmag;
					is_lcm_d = req.cmd;
					quot_d   = 1'b0;
					if (!(req.left_integral && req.right_integral)) begin
						res_d   = '{result: '0, status: STAT_NONINT};
						state_d = S_DONE;
					end else if (req.cmd == CMD_LCM && (lmag == '0 || rmag == '0)) begin
						res_d   = '{result: '0, status: STAT_OK};
						state_d = S_DONE;
					end else begin
						state_d = S_TEST;
					end
				end
			end
			S_TEST: begin
				rem_d = '0;
				cnt_d = '0;
				if (b_q == '0) begin
					if (!is_lcm_q) begin
						if (a_q[DATA_W-1])
							res_d = '{result: '0, status: STAT_OVF};
						else
							res_d = '{result: a_q[RES_W-1:0], status: STAT_OK};
						state_d = S_DONE;
					end else begin
						quo_d   = amag_q;
						b_d     = a_q;
						quot_d  = 1'b1;
						state_d = S_DIV;
					end
				end else begin
					quo_d   = a_q;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				qbit = !alu_sum[DATA_W];
				if (qbit)
					rem_d = alu_sum[RES_W-1:0];
				else
					rem_d = {rem_q[RES_W-2:0], quo_q[DATA_W-1]};
				quo_d = {quo_q[DATA_W-2:0], qbit};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					cnt_d = '0;
					if (quot_q) begin
						acc_d   = '0;
						ovf_d   = 1'b0;
						state_d = S_MUL;
					end else begin
						a_d     = b_q;
						b_d     = {1'b0, rem_d};
						state_d = S_TEST;
					end
				end
			end
			S_MUL: begin
				alu_a   = {1'b0, acc_q, 1'b0};
				alu_b   = quo_q[DATA_W-1] ? {1'b0, bmag_q} : '0;
				alu_sub = 1'b0;
				ovf_n   = ovf_q | alu_sum[DATA_W] | alu_sum[DATA_W-1];
				ovf_d   = ovf_n;
				acc_d   = alu_sum[RES_W-1:0];
				quo_d   = {quo_q[DATA_W-2:0], 1'b0};
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					if (ovf_n)
						res_d = '{result: '0, status: STAT_OVF};
					else
						res_d = '{result: alu_sum[RES_W-1:0], status: STAT_OK};
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (ack)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		is_lcm_q <= is_lcm_d;
		quot_q   <= quot_d;
		ovf_q    <= ovf_d;
		cnt_q    <= cnt_d;
		a_q      <= a_d;
		b_q      <= b_d;
		amag_q   <= amag_d;
		bmag_q   <= bmag_d;
		quo_q    <= quo_d;
		rem_q    <= rem_d;
		acc_q    <= acc_d;
		res_q    <= res_d;
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);
	assign res  = res_q;

endmodule

@@ hdl/gclu_core_checker.sv @@
// gclu_core_checker: port-level assertions for gcd_lcm_unit_core, bound to it below.
// Depends on gclu_pkg and gcd_lcm_unit_core.
module gclu_core_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [63:0]  m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);
	import gclu_pkg::*;

	// busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted a second request back to back");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_NONINT ||
		                   m_axis_tuser == STAT_OVF))
		else $error("bad status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata == '0)
		else $error("nonzero result with error status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("output changed while stalled");

endmodule

bind gcd_lcm_unit_core gclu_core_checker u_chk (.*);

@@ test/gclu_core_checker.sv @@
// gclu_tb_checker: watches both stream channels of gcd_lcm_unit_core, predicts each
// result from the accepted request and compares it with what the unit returns.
// Depends on gclu_pkg.
module gclu_tb_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,
	input  logic [2:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [63:0]  m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,
	output int           mismatches,
	output int           pending
);
	import gclu_pkg::*;

	localparam logic [DATA_W-1:0] MAG_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	res_t expected_results[$];
	res_t want;
	res_t got;
	req_t accepted;
	int   fail_count = 0;

	function automatic logic [DATA_W-1:0] euclid_gcd(logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] rem;
		while (b != '0) begin
			rem = a % b;
			a = b;
			b = rem;
		end
		return a;
	endfunction

	function automatic res_t expected_gcd_lcm(req_t rq);
		logic [DATA_W-1:0] mag_a;
		logic [DATA_W-1:0] mag_b;
		logic [DATA_W-1:0] g;
		logic [DATA_W-1:0] quot;
		logic [DATA_W-1:0] prod;
		res_t res;
		mag_a = rq.lhs_val[DATA_W-1] ? DATA_W'(0) - rq.lhs_val : rq.lhs_val;
		mag_b = rq.rhs_val[DATA_W-1] ? DATA_W'(0) - rq.rhs_val : rq.rhs_val;
		res.result = '0;
		res.status = STAT_OK;
		if (!rq.left_integral || !rq.right_integral) begin
			res.status = STAT_NONINT;
		end else if (rq.cmd == CMD_GCD) begin
			g = euclid_gcd(mag_a, mag_b);
			if (g > MAG_MAX)
				res.status = STAT_OVF;
			else
				res.result = g[RES_W-1:0];
		end else if (mag_a != '0 && mag_b != '0) begin
			g = euclid_gcd(mag_a, mag_b);
			quot = mag_a / g;
			if (quot > MAG_MAX / mag_b) begin
				res.status = STAT_OVF;
			end else begin
				prod = quot * mag_b;
				res.result = prod[RES_W-1:0];
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.result = m_axis_tdata[RES_W-1:0];
				got.status = m_axis_tuser;
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t unexpected result transaction: result %0d status %0d",
						$time, got.result, got.status);
				end else begin
					want = expected_results.pop_front();
					if (got.result !== want.result || got.status !== want.status) begin
						fail_count++;
						$display({"%0t mismatch: expected result %0d status %0d,",
							" got result %0d status %0d"},
							$time, want.result, want.status, got.result, got.status);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				accepted.cmd            = s_axis_tuser[0];
				accepted.left_integral  = s_axis_tuser[1];
				accepted.right_integral = s_axis_tuser[2];
				accepted.lhs_val        = s_axis_tdata[63:0];
				accepted.rhs_val        = s_axis_tdata[127:64];
				expected_results.push_back(expected_gcd_lcm(accepted));
			end
		end
		mismatches <= fail_count;
		pending    <= expected_results.size();
	end

endmodule

@@ test/tb_gcd_lcm_unit_core.sv @@
// tb_gcd_lcm_unit_core: drives directed and random GCD/LCM requests into
// gcd_lcm_unit_core under varying sender gaps and receiver stalls.
// Depends on gclu_pkg, gcd_lcm_unit_core and gclu_tb_checker.
module tb_gcd_lcm_unit_core;
	import gclu_pkg::*;

	localparam int WATCHDOG_LIMIT = 50000;
	localparam int DRAIN_CYCLES   = 300;
	localparam logic [63:0] V_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] V_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] FIB92 = 64'd7540113804746346429;
	localparam logic [63:0] FIB91 = 64'd4660046610375530309;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	int mismatches;
	int pending;
	int quiet_cycles = 0;
	int send_idle = 0;
	int recv_stall = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	gcd_lcm_unit_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	gclu_tb_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [63:0] negate(logic [63:0] v);
		return 64'd0 - v;
	endfunction

	function automatic req_t make_req(logic cmd, logic [63:0] lv, logic li,
			logic [63:0] rv, logic ri);
		req_t rq;
		rq.cmd            = cmd;
		rq.lhs_val        = lv;
		rq.left_integral  = li;
		rq.rhs_val        = rv;
		rq.right_integral = ri;
		return rq;
	endfunction

	function automatic logic [63:0] rand_operand();
		logic [63:0] v;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 68) begin
			v = 64'($urandom_range(1024));
		end else if (pick < 83) begin
			v = 64'($urandom);
		end else if (pick < 92) begin
			v = {$urandom, $urandom};
		end else begin
			case ($urandom_range(4))
				0: v = 64'd0;
				1: v = 64'd1;
				2: v = V_MIN;
				3: v = V_MAX;
				default: v = 64'd1 << $urandom_range(63);
			endcase
		end
		if (pick < 83 || pick >= 92) begin
			if ($urandom_range(1))
				v = negate(v);
		end
		return v;
	endfunction

	function automatic req_t rand_request();
		logic [63:0] lv;
		logic [63:0] rv;
		logic [63:0] factor;
		if ($urandom_range(99) < 30) begin
			factor = 64'($urandom_range(4096, 2));
			lv = factor * 64'($urandom_range(1024));
			rv = factor * 64'($urandom_range(1024));
			if ($urandom_range(1))
				lv = negate(lv);
			if ($urandom_range(1))
				rv = negate(rv);
		end else begin
			lv = rand_operand();
			rv = rand_operand();
		end
		return make_req(logic'($urandom_range(1)), lv, ($urandom_range(99) < 94),
			rv, ($urandom_range(99) < 94));
	endfunction

	task automatic send_request(req_t rq);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {rq.rhs_val, rq.lhs_val};
		s_axis_tuser  <= {rq.right_integral, rq.left_integral, rq.cmd};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic run_random(int count, int sidle, int rstall, bit drain);
		send_idle  = sidle;
		recv_stall = rstall;
		for (int i = 0; i < count; i++)
			send_request(rand_request());
		if (drain)
			wait_drained();
	endtask

	initial begin
		int pct_pick[3];
		pct_pick = '{0, 74, 18};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_req(CMD_GCD, 64'd0, 1'b1, 64'd0, 1'b1));
		send_request(make_req(CMD_LCM, 64'd0, 1'b1, 64'd0, 1'b1));
		send_request(make_req(CMD_GCD, V_MIN, 1'b1, 64'd0, 1'b1));
		send_request(make_req(CMD_GCD, 64'd0, 1'b1, V_MIN, 1'b1));
		send_request(make_req(CMD_GCD, V_MIN, 1'b1, V_MIN, 1'b1));
		send_request(make_req(CMD_LCM, V_MIN, 1'b1, 64'd1, 1'b1));
		send_request(make_req(CMD_LCM, 64'd1, 1'b1, V_MIN, 1'b1));
		send_request(make_req(CMD_LCM, V_MAX, 1'b1, V_MAX, 1'b1));
		send_request(make_req(CMD_GCD, V_MAX, 1'b1, negate(V_MAX), 1'b1));
		send_request(make_req(CMD_GCD, V_MIN, 1'b1, V_MAX, 1'b1));
		send_request(make_req(CMD_GCD, V_MIN, 1'b1, 64'd2, 1'b1));
		send_request(make_req(CMD_GCD, 64'd12, 1'b0, 64'd18, 1'b1));
		send_request(make_req(CMD_LCM, 64'd12, 1'b1, 64'd18, 1'b0));
		send_request(make_req(CMD_GCD, V_MIN, 1'b0, V_MIN, 1'b0));
		send_request(make_req(CMD_LCM, V_MAX, 1'b0, 64'd2, 1'b1));
		send_request(make_req(CMD_LCM, negate(64'd6), 1'b1, 64'd4, 1'b1));
		send_request(make_req(CMD_GCD, negate(64'd12), 1'b1, 64'd18, 1'b1));
		send_request(make_req(CMD_LCM, 64'd1 << 32, 1'b1, 64'd1 << 31, 1'b1));
		send_request(make_req(CMD_LCM, (64'd1 << 32) + 64'd1, 1'b1, 64'd1 << 31, 1'b1));
		send_request(make_req(CMD_LCM, 64'd0, 1'b1, 64'd5, 1'b1));
		send_request(make_req(CMD_LCM, negate(64'd7), 1'b1, 64'd0, 1'b1));
		send_request(make_req(CMD_GCD, FIB92, 1'b1, FIB91, 1'b1));
		send_request(make_req(CMD_LCM, negate(FIB91), 1'b1, FIB92, 1'b1));
		send_request(make_req(CMD_LCM, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
		send_request(make_req(CMD_LCM, V_MAX, 1'b1, 64'd2, 1'b1));
		wait_drained();

		run_random(280, 0, 0, 1'b1);
		run_random(280, 74, 0, 1'b1);
		run_random(280, 0, 74, 1'b1);
		run_random(280, 18, 18, 1'b1);
		for (int c = 0; c < 11; c++)
			run_random(30, pct_pick[$urandom_range(2)], pct_pick[$urandom_range(2)], 1'b0);

		recv_stall = 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
hdl/gclu_pkg.sv
hdl/gclu_alu.sv
hdl/gclu_engine.sv
hdl/gcd_lcm_unit_core.sv
hdl/gclu_core_checker.sv
test/gclu_core_checker.sv
test/tb_gcd_lcm_unit_core.sv
